FILE: rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// BMP byte stream decoder package
// Item types, result kinds and shared constants of the decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;

	localparam int ROWCOL_W = 13;
	localparam int BPP_W    = 16;

	// header layout (byte offsets within the fixed 54-byte header)
	localparam logic [5:0] HDR_WIDTH_0  = 6'd18;
	localparam logic [5:0] HDR_WIDTH_1  = 6'd19;
	localparam logic [5:0] HDR_WIDTH_2  = 6'd20;
	localparam logic [5:0] HDR_WIDTH_3  = 6'd21;
	localparam logic [5:0] HDR_HEIGHT_0 = 6'd22;
	localparam logic [5:0] HDR_HEIGHT_1 = 6'd23;
	localparam logic [5:0] HDR_HEIGHT_2 = 6'd24;
	localparam logic [5:0] HDR_HEIGHT_3 = 6'd25;
	localparam logic [5:0] HDR_BPP_0    = 6'd28;
	localparam logic [5:0] HDR_BPP_1    = 6'd29;
	localparam logic [5:0] HDR_LAST     = 6'd53;

	localparam logic [15:0] BPP_32 = 16'd32;

	localparam logic [2:0] KIND_HEADER    = 3'd0;
	localparam logic [2:0] KIND_PIXEL     = 3'd1;
	localparam logic [2:0] KIND_TRUNCATED = 3'd2;
	localparam logic [2:0] KIND_TRAILING  = 3'd3;
	localparam logic [2:0] KIND_TOO_LARGE = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [7:0]          blue;
		logic [7:0]          green;
		logic [7:0]          red;
		logic [7:0]          alpha;
		logic [ROWCOL_W-1:0] row;
		logic [ROWCOL_W-1:0] col;
		logic [BPP_W-1:0]    bits_per_pixel;
		logic                last_pixel;
	} out_item_t;

endpackage

FILE: rtl/bmpd_parser.sv
// ----------------------------------------------------------------------------
// BMP decoder parser
// Header capture, pixel assembly, row padding skip and error detection.
// Produces at most one result for each byte it is handed.
// ----------------------------------------------------------------------------
module bmpd_parser
	import bmpd_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PIXEL,
		PH_PAD,
		PH_DONE,
		PH_IGNORE
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [5:0]       hdr_cnt_q, hdr_cnt_d;
	logic [31:0]      width_q, width_d;
	logic [31:0]      height_q, height_d;
	logic [15:0]      depth_q, depth_d;
	logic [1:0]       byte_idx_q, byte_idx_d;
	logic [7:0]       blue_q, blue_d;
	logic [7:0]       green_q, green_d;
	logic [7:0]       red_q, red_d;
	logic [DIM_W-1:0] row_q, row_d;
	logic [DIM_W-1:0] col_q, col_d;
	logic [1:0]       pad_rem_q, pad_rem_d;
	logic [1:0]       pad_amt_q, pad_amt_d;
	logic             trail_q, trail_d;

	logic [7:0]       b;
	logic             four_bytes;
	logic             pix_done;
	logic [DIM_W-1:0] row_inc;
	logic [DIM_W-1:0] col_inc;
	logic [1:0]       pad_prod;
	logic [1:0]       pad_rem_dec;
	logic             rows_done;

	assign b           = item.data_byte;
	assign four_bytes  = (depth_q == BPP_32);
	assign pix_done    = four_bytes ? (byte_idx_q == 2'd3) : (byte_idx_q == 2'd2);
	assign row_inc     = row_q + 1'b1;
	assign col_inc     = col_q + 1'b1;
	assign pad_prod    = 2'(width_q[1:0] * depth_q[4:3]);
	assign pad_rem_dec = (pad_rem_q != 2'd0) ? pad_rem_q - 2'd1 : 2'd0;
	assign rows_done   = (32'(row_q) == height_q);

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		width_d    = width_q;
		height_d   = height_q;
		depth_d    = depth_q;
		byte_idx_d = byte_idx_q;
		blue_d     = blue_q;
		green_d    = green_q;
		red_d      = red_q;
		row_d      = row_q;
		col_d      = col_q;
		pad_rem_d  = pad_rem_q;
		pad_amt_d  = pad_amt_q;
		trail_d    = trail_q;
		res_valid  = 1'b0;
		res        = '0;

		if (step && item.end_marker) begin
			if (phase_q == PH_HEADER && hdr_cnt_q != 6'd0) begin
				res_valid = 1'b1;
				res.kind  = KIND_TRUNCATED;
			end else if (phase_q == PH_PIXEL || (phase_q == PH_PAD && !rows_done)) begin
				res_valid = 1'b1;
				res.kind  = KIND_TRUNCATED;
				res.row   = ROWCOL_W'(row_q);
				res.col   = ROWCOL_W'(col_q);
			end
			// every end of stream returns to the reset state
			phase_d    = PH_HEADER;
			hdr_cnt_d  = '0;
			width_d    = '0;
			height_d   = '0;
			depth_d    = '0;
			byte_idx_d = '0;
			blue_d     = '0;
			green_d    = '0;
			red_d      = '0;
			row_d      = '0;
			col_d      = '0;
			pad_rem_d  = '0;
			pad_amt_d  = '0;
			trail_d    = 1'b0;
		end else if (step) begin
			case (phase_q)
				PH_HEADER: begin
					case (hdr_cnt_q)
						HDR_WIDTH_0:  width_d[7:0]   = b;
						HDR_WIDTH_1:  width_d[15:8]  = b;
						HDR_WIDTH_2:  width_d[23:16] = b;
						HDR_WIDTH_3:  width_d[31:24] = b;
						HDR_HEIGHT_0: height_d[7:0]   = b;
						HDR_HEIGHT_1: height_d[15:8]  = b;
						HDR_HEIGHT_2: height_d[23:16] = b;
						HDR_HEIGHT_3: height_d[31:24] = b;
						HDR_BPP_0:    depth_d[7:0]  = b;
						HDR_BPP_1:    depth_d[15:8] = b;
						default: ;
					endcase
					hdr_cnt_d = hdr_cnt_q + 6'd1;
					if (hdr_cnt_q == HDR_LAST) begin
						res_valid = 1'b1;
						if (width_q > 32'(MAX_DIMENSION) || height_q > 32'(MAX_DIMENSION)) begin
							phase_d  = PH_IGNORE;
							res.kind = KIND_TOO_LARGE;
						end else begin
							pad_amt_d  = four_bytes ? 2'd0 : 2'(2'd0 - pad_prod);
							row_d      = '0;
							col_d      = '0;
							byte_idx_d = '0;
							blue_d     = '0;
							green_d    = '0;
							red_d      = '0;
							phase_d    = (width_q == 32'd0 || height_q == 32'd0) ?
								PH_DONE : PH_PIXEL;
							res.kind           = KIND_HEADER;
							res.row            = ROWCOL_W'(height_q);
							res.col            = ROWCOL_W'(width_q);
							res.bits_per_pixel = depth_q;
						end
					end
				end
				PH_PIXEL: begin
					if (!pix_done) begin
						case (byte_idx_q)
							2'd0:    blue_d  = b;
							2'd1:    green_d = b;
							default: red_d   = b;
						endcase
						byte_idx_d = byte_idx_q + 2'd1;
					end else begin
						res_valid      = 1'b1;
						res.kind       = KIND_PIXEL;
						res.blue       = blue_q;
						res.green      = green_q;
						res.red        = four_bytes ? red_q : b;
						res.alpha      = four_bytes ? b : 8'd0;
						res.row        = ROWCOL_W'(row_q);
						res.col        = ROWCOL_W'(col_q);
						res.last_pixel = (32'(row_inc) == height_q) &&
							(32'(col_inc) == width_q);
						byte_idx_d = '0;
						blue_d     = '0;
						green_d    = '0;
						red_d      = '0;
						col_d      = col_inc;
						if (32'(col_inc) == width_q) begin
							col_d = '0;
							row_d = row_inc;
							if (pad_amt_q != 2'd0) begin
								pad_rem_d = pad_amt_q;
								phase_d   = PH_PAD;
							end else if (32'(row_inc) == height_q) begin
								phase_d = PH_DONE;
							end
						end
					end
				end
				PH_PAD: begin
					pad_rem_d = pad_rem_dec;
					if (pad_rem_dec == 2'd0) begin
						phase_d = rows_done ? PH_DONE : PH_PIXEL;
					end
				end
				PH_DONE: begin
					if (!trail_q) begin
						trail_d   = 1'b1;
						res_valid = 1'b1;
						res.kind  = KIND_TRAILING;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			byte_idx_q <= '0;
			blue_q     <= '0;
			green_q    <= '0;
			red_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pad_rem_q  <= '0;
			pad_amt_q  <= '0;
			trail_q    <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			width_q    <= width_d;
			height_q   <= height_d;
			depth_q    <= depth_d;
			byte_idx_q <= byte_idx_d;
			blue_q     <= blue_d;
			green_q    <= green_d;
			red_q      <= red_d;
			row_q      <= row_d;
			col_q      <= col_d;
			pad_rem_q  <= pad_rem_d;
			pad_amt_q  <= pad_amt_d;
			trail_q    <= trail_d;
		end
	end

endmodule

FILE: rtl/bmpd_out_buf.sv
// ----------------------------------------------------------------------------
// BMP decoder result buffer
// Result register with a skid stage so that a waiting result does not
// block the parser for one extra transfer.
// ----------------------------------------------------------------------------
module bmpd_out_buf
	import bmpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      full,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic      out_valid_q;
	out_item_t out_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      out_free;

	// the result register can take a new value this cycle
	assign out_free  = !out_valid_q || !res_stall;
	assign full      = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (!res_stall) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!res_stall) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_free) begin
				out_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end
	end

endmodule

FILE: rtl/bmp_byte_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// BMP byte stream decoder
// Parses a 24/32 bpp BMP file one byte per transfer and emits header,
// pixel and error results.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while item_stall is low. A transfer is held
// in an input register, the combinational parser handles it from there and any
// result is registered in the result register, or in the skid stage while the
// result register is stalled. The result side has a one-entry skid stage: the
// input stalls while that entry is occupied and a byte waits in the input
// register; once the result side takes a result the skid entry moves up, and
// input transfers resume.
// Results: header done (height, width, bit depth), one pixel per 3 or 4 bytes,
// truncated stream, trailing data (once) and image too large, after which bytes
// are dropped until an end marker. Every end marker restarts header parsing.
// ----------------------------------------------------------------------------
module bmp_byte_stream_decoder_top
	import bmpd_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      buf_full;
	logic      advance;
	logic      take;
	logic      parse_valid;
	out_item_t parse_res;

	assign advance    = valid_s1 && !buf_full;
	assign item_stall = valid_s1 && buf_full;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	bmpd_parser #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.res_valid(parse_valid),
		.res      (parse_res)
	);

	bmpd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (parse_valid),
		.push_item(parse_res),
		.full     (buf_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

FILE: tb/tb_bmp_byte_stream_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP byte stream decoder testbench
// Streams BMP files byte by byte into the decoder, with short directed files
// first and then random well-formed, cut, padded and oversize files plus
// noise. A scoreboard predicts every header, pixel and error result and
// compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_bmp_byte_stream_decoder_top
	import bmpd_pkg::*;
();

	localparam int        RANDOM_ITEMS = 550;
	localparam int        CYCLE_LIMIT  = 2_000_000;
	localparam int        DRAIN_CYCLES = 16;
	localparam int        HDR_BYTES    = 54;
	localparam bit [31:0] MAX_DIM      = MAX_DIMENSION_DEF;

	typedef enum logic [2:0] {
		PH_HEADER, PH_PIXEL, PH_PAD, PH_DONE, PH_IGNORE
	} parse_phase_t;

	typedef enum {FILE_CLEAN, FILE_CUT, FILE_TRAIL} file_mode_t;

	class bmp_scoreboard;
		parse_phase_t phase      = PH_HEADER;
		int unsigned  hdr_count  = 0;
		bit [31:0]    img_w      = 0;
		bit [31:0]    img_h      = 0;
		bit [15:0]    depth      = 0;
		int unsigned  byte_idx   = 0;
		bit [23:0]    partial    = 0;
		bit [31:0]    row_cnt    = 0;
		bit [31:0]    col_cnt    = 0;
		bit [1:0]     pad_left   = 0;
		bit [1:0]     pad_amt    = 0;
		bit           trail_seen = 0;
		out_item_t    expected_q[$];
		int           errors     = 0;
		int           kind_seen[5];

		function void restart();
			phase      = PH_HEADER;
			hdr_count  = 0;
			img_w      = 0;
			img_h      = 0;
			depth      = 0;
			byte_idx   = 0;
			partial    = 0;
			row_cnt    = 0;
			col_cnt    = 0;
			pad_left   = 0;
			pad_amt    = 0;
			trail_seen = 0;
		endfunction

		// Advance the decoder state by one accepted input transfer.
		function void note_transfer(in_item_t it);
			out_item_t   r;
			bit          emit;
			int unsigned idx;
			int unsigned nbytes;
			bit [7:0]    b;
			r    = '0;
			emit = 1'b0;
			b    = it.data_byte;
			if (it.end_marker) begin
				if (phase == PH_HEADER && hdr_count != 0) begin
					r.kind = KIND_TRUNCATED;
					emit   = 1'b1;
				end else if (phase == PH_PIXEL || (phase == PH_PAD && row_cnt != img_h)) begin
					r.kind = KIND_TRUNCATED;
					r.row  = row_cnt[ROWCOL_W-1:0];
					r.col  = col_cnt[ROWCOL_W-1:0];
					emit   = 1'b1;
				end
				restart();
			end else begin
				case (phase)
					PH_HEADER: begin
						idx = hdr_count;
						if (idx >= HDR_WIDTH_0 && idx <= HDR_WIDTH_3)
							img_w |= 32'(b) << (8 * (idx - HDR_WIDTH_0));
						else if (idx >= HDR_HEIGHT_0 && idx <= HDR_HEIGHT_3)
							img_h |= 32'(b) << (8 * (idx - HDR_HEIGHT_0));
						else if (idx >= HDR_BPP_0 && idx <= HDR_BPP_1)
							depth |= 16'(b) << (8 * (idx - HDR_BPP_0));
						hdr_count = idx + 1;
						if (idx == HDR_LAST) begin
							if (img_w > MAX_DIM || img_h > MAX_DIM) begin
								phase  = PH_IGNORE;
								r.kind = KIND_TOO_LARGE;
							end else begin
								if (depth == BPP_32)
									pad_amt = 2'd0;
								else
									pad_amt = 2'((4 - ((img_w & 3) * ((depth / 8) & 3)) % 4) % 4);
								row_cnt  = 0;
								col_cnt  = 0;
								byte_idx = 0;
								partial  = 0;
								phase    = (img_w == 0 || img_h == 0) ? PH_DONE : PH_PIXEL;
								r.kind           = KIND_HEADER;
								r.row            = img_h[ROWCOL_W-1:0];
								r.col            = img_w[ROWCOL_W-1:0];
								r.bits_per_pixel = depth;
							end
							emit = 1'b1;
						end
					end
					PH_PIXEL: begin
						nbytes = (depth == BPP_32) ? 4 : 3;
						if (byte_idx + 1 < nbytes) begin
							partial |= 24'(b) << (8 * byte_idx);
							byte_idx++;
						end else begin
							if (nbytes == 3)
								partial[23:16] = partial[23:16] | b;
							r.kind       = KIND_PIXEL;
							r.blue       = partial[7:0];
							r.green      = partial[15:8];
							r.red        = partial[23:16];
							r.alpha      = (nbytes == 4) ? b : 8'd0;
							r.row        = row_cnt[ROWCOL_W-1:0];
							r.col        = col_cnt[ROWCOL_W-1:0];
							r.last_pixel = (row_cnt + 1 == img_h) && (col_cnt + 1 == img_w);
							emit         = 1'b1;
							byte_idx     = 0;
							partial      = 0;
							col_cnt      = col_cnt + 1;
							if (col_cnt == img_w) begin
								col_cnt = 0;
								row_cnt = row_cnt + 1;
								if (pad_amt != 0) begin
									pad_left = pad_amt;
									phase    = PH_PAD;
								end else if (row_cnt == img_h) begin
									phase = PH_DONE;
								end
							end
						end
					end
					PH_PAD: begin
						if (pad_left != 0)
							pad_left--;
						if (pad_left == 0)
							phase = (row_cnt == img_h) ? PH_DONE : PH_PIXEL;
					end
					PH_DONE: begin
						if (!trail_seen) begin
							trail_seen = 1'b1;
							r.kind     = KIND_TRAILING;
							emit       = 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (emit)
				expected_q.insert(expected_q.size(), r);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: kind %0d", got.kind);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("kind", want.kind, got.kind);
			compare("blue", want.blue, got.blue);
			compare("green", want.green, got.green);
			compare("red", want.red, got.red);
			compare("alpha", want.alpha, got.alpha);
			compare("row", want.row, got.row);
			compare("col", want.col, got.col);
			compare("bits_per_pixel", want.bits_per_pixel, got.bits_per_pixel);
			compare("last_pixel", want.last_pixel, got.last_pixel);
			if (want.kind <= KIND_TOO_LARGE)
				kind_seen[want.kind]++;
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      res_valid;
	logic      res_stall;
	out_item_t res;

	bmp_scoreboard sb = new;
	int            items_sent   = 0;
	int            cycles       = 0;
	bit            feed_gaps    = 1'b0;
	bit            drain_stalls = 1'b0;

	bmp_byte_stream_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$error("no progress after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Output stall bursts
	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (drain_stalls && $urandom_range(0, 6) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	task automatic push_item(input logic [7:0] b, input logic eom);
		if (feed_gaps && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{data_byte: b, end_marker: eom};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_transfer(item);
		items_sent++;
	endtask

	task automatic push_end();
		push_item(8'($urandom), 1'b1);
	endtask

	task automatic send_random_bytes(input int n);
		repeat (n) push_item(8'($urandom), 1'b0);
	endtask

	// Send the first upto bytes of a header; unused fields get random bytes.
	task automatic send_header(input bit [31:0] w, input bit [31:0] h, input bit [15:0] bpp,
			input int upto);
		logic [7:0] b;
		for (int i = 0; i < upto; i++) begin
			b = 8'($urandom);
			if (i >= HDR_WIDTH_0 && i <= HDR_WIDTH_3)
				b = w[8 * (i - HDR_WIDTH_0) +: 8];
			else if (i >= HDR_HEIGHT_0 && i <= HDR_HEIGHT_3)
				b = h[8 * (i - HDR_HEIGHT_0) +: 8];
			else if (i >= HDR_BPP_0 && i <= HDR_BPP_1)
				b = bpp[8 * (i - HDR_BPP_0) +: 8];
			push_item(b, 1'b0);
		end
	endtask

	task automatic send_file(input bit [31:0] w, input bit [31:0] h, input bit [15:0] bpp,
			input file_mode_t mode);
		int row_bytes;
		int body;
		send_header(w, h, bpp, HDR_BYTES);
		if (w > MAX_DIM || h > MAX_DIM) begin
			send_random_bytes($urandom_range(0, 6));
			push_end();
			return;
		end
		row_bytes = (bpp == BPP_32) ? w * 4 : w * 3 + (4 - (w * (bpp / 8)) % 4) % 4;
		body      = row_bytes * h;
		if (body == 0)
			mode = FILE_TRAIL;
		case (mode)
			FILE_CLEAN: send_random_bytes(body);
			FILE_CUT:   send_random_bytes($urandom_range(0, body > 40 ? 40 : body - 1));
			default:    send_random_bytes(body + $urandom_range(1, 5));
		endcase
		push_end();
	endtask

	initial begin
		bit [31:0]  w;
		bit [31:0]  h;
		bit [15:0]  bpp;
		int         choice;
		int         directed_end;
		file_mode_t mode;

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		feed_gaps    = 1'b1;
		drain_stalls = 1'b1;
		push_end();
		send_header(5, 3, 24, 1);
		push_end();
		send_header(5, 3, 24, HDR_BYTES - 1);
		push_end();
		send_file(1, 1, 24, FILE_CLEAN);
		send_file(1, 1, 32, FILE_TRAIL);
		send_file(2, 2, 16'hFFFF, FILE_CLEAN);
		send_file(3, 1, 8, FILE_CLEAN);
		send_file(1, 3, 16, FILE_CLEAN);
		send_file(2, 1, 16'd0, FILE_TRAIL);
		send_file(0, 7, 24, FILE_TRAIL);
		send_file(9, 0, 32, FILE_TRAIL);
		send_file(4097, 1, 24, FILE_CLEAN);
		send_file(1, 32'hFFFF_FFFF, 24, FILE_CLEAN);
		send_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32, FILE_CLEAN);
		send_file(4096, 4096, 24, FILE_CUT);
		send_file(4096, 1, 32, FILE_CUT);
		// pixel components at both extremes
		send_header(2, 1, 32, HDR_BYTES);
		repeat (4) push_item(8'h00, 1'b0);
		repeat (4) push_item(8'hFF, 1'b0);
		push_end();
		// end marker in the padding of an inner row, then of the last row
		send_header(1, 2, 24, HDR_BYTES);
		send_random_bytes(3);
		push_end();
		send_header(1, 2, 24, HDR_BYTES);
		send_random_bytes(7);
		push_end();
		directed_end = items_sent;

		while (items_sent < directed_end + RANDOM_ITEMS) begin
			if (items_sent > directed_end + RANDOM_ITEMS - 300) begin
				feed_gaps    = 1'b0;
				drain_stalls = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				feed_gaps    = $urandom_range(0, 1);
				drain_stalls = $urandom_range(0, 1);
			end
			choice = $urandom_range(0, 99);
			w      = $urandom_range(1, 6);
			h      = $urandom_range(1, 4);
			case ($urandom_range(0, 5))
				0, 1:    bpp = 16'd24;
				2, 3:    bpp = BPP_32;
				4:       bpp = $urandom_range(0, 1) ? 16'd8 : 16'd16;
				default: bpp = 16'($urandom);
			endcase
			if (choice < 5) begin
				// noise with stray end markers
				repeat ($urandom_range(1, 40)) push_item(8'($urandom), $urandom_range(0, 7) == 0);
				push_end();
			end else if (choice < 10) begin
				send_header(w, h, bpp, $urandom_range(1, HDR_BYTES - 1));
				push_end();
			end else begin
				if (choice < 14) begin
					if ($urandom_range(0, 1))
						w = 0;
					else
						h = 0;
				end else if (choice < 18) begin
					if ($urandom_range(0, 1))
						w = MAX_DIM + 1 + $urandom_range(0, 3);
					else
						h = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom) | 32'h0001_0000;
				end
				mode = (choice < 55) ? FILE_CLEAN : (choice < 80) ? FILE_CUT : FILE_TRAIL;
				send_file(w, h, bpp, mode);
			end
		end
		item_valid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d byte transfers, directed and random files with gaps and stalls.",
			items_sent);
		$display("Checked %0d header, %0d pixel, %0d truncated, %0d trailing, %0d oversize results.",
			sb.kind_seen[KIND_HEADER], sb.kind_seen[KIND_PIXEL], sb.kind_seen[KIND_TRUNCATED],
			sb.kind_seen[KIND_TRAILING], sb.kind_seen[KIND_TOO_LARGE]);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
